// ----- rtl/pvi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pvi_pkg;

  // step counter width
  localparam int COUNT_BITS = 16;

  // stream word widths, fields packed from bit 0 and padded to whole bytes
  localparam int IN_BITS  = 64 + COUNT_BITS;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int VEL_W    = 32;
  localparam int GAIN_W   = 24;
  localparam int PROD_W   = VEL_W + GAIN_W;   // shared multiplier result
  localparam int ACC_W    = 60;               // kp*e + 10*kd*d + ki*sum
  localparam int WIDE_W   = 45;               // headroom ahead of saturation
  localparam int FRAC_W   = 16;

  // dt = 0.1 in Q0.16
  localparam logic signed [GAIN_W-1:0] DT_Q16 = 24'sd6554;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_PROP  = 2'd0,
    CFG_INTEG = 2'd1,
    CFG_DERIV = 2'd2
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_t;

  // microcode fields
  typedef enum logic [1:0] {
    A_ERR,
    A_DIFF,
    A_SUM
  } a_sel_t;

  typedef enum logic [1:0] {
    B_KP,
    B_KI,
    B_KD,
    B_DT
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD10
  } acc_op_t;

  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    logic    mul_en;
    logic    ld_err;
    logic    ld_diff;
    logic    ld_sum;
    acc_op_t acc_op;
    logic    ld_vel;
    logic    loop_end;
  } ctrl_word_t;

  localparam int UPC_W = 3;
  localparam logic [UPC_W-1:0] UPC_FIRST = 3'd0;

  // one pid step: 7 control words
  function automatic ctrl_word_t ucode(input logic [UPC_W-1:0] upc);
    ctrl_word_t cw;
    cw = '{a_sel: A_ERR, b_sel: B_KP, mul_en: 1'b0, ld_err: 1'b0, ld_diff: 1'b0,
           ld_sum: 1'b0, acc_op: ACC_HOLD, ld_vel: 1'b0, loop_end: 1'b0};
    unique case (upc)
      3'd0: cw.ld_err = 1'b1;
      3'd1: begin
        cw.ld_diff = 1'b1;
        cw.mul_en  = 1'b1;
        cw.a_sel   = A_ERR;
        cw.b_sel   = B_KP;
      end
      3'd2: begin
        cw.acc_op = ACC_LOAD;
        cw.mul_en = 1'b1;
        cw.a_sel  = A_ERR;
        cw.b_sel  = B_DT;
      end
      3'd3: begin
        cw.ld_sum = 1'b1;
        cw.mul_en = 1'b1;
        cw.a_sel  = A_DIFF;
        cw.b_sel  = B_KD;
      end
      3'd4: begin
        cw.acc_op = ACC_ADD10;
        cw.mul_en = 1'b1;
        cw.a_sel  = A_SUM;
        cw.b_sel  = B_KI;
      end
      3'd5: cw.acc_op = ACC_ADD;
      3'd6: begin
        cw.ld_vel   = 1'b1;
        cw.loop_end = 1'b1;
      end
      default: cw.loop_end = 1'b1;
    endcase
    return cw;
  endfunction

  typedef struct packed {
    logic signed [VEL_W-1:0] val;
    logic                    ovf;
  } sat_t;

  // clamp to the signed 32-bit range
  function automatic sat_t sat32(input logic signed [WIDE_W-1:0] x);
    sat_t r;
    r.ovf = !((&x[WIDE_W-1:VEL_W-1]) || !(|x[WIDE_W-1:VEL_W-1]));
    if (r.ovf) begin
      r.val = x[WIDE_W-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
    end else begin
      r.val = x[VEL_W-1:0];
    end
    return r;
  endfunction

  // round half up, then drop the fraction
  function automatic logic signed [PROD_W-FRAC_W-1:0] rnd_prod(
      input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] y;
    y = x + PROD_W'(32768);
    return y[PROD_W-1:FRAC_W];
  endfunction

  function automatic logic signed [ACC_W-FRAC_W-1:0] rnd_acc(
      input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] y;
    y = x + ACC_W'(32768);
    return y[ACC_W-1:FRAC_W];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pid_velocity_iterate.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel  | ports                          | word
// ---------+--------------------------------+-------------------------------------------
// input    | s_tvalid s_tready s_tdata      | target, start velocity, step count
// output   | m_tvalid m_tready m_tdata/tuser| final velocity, saturation flag
// config   | cfg_valid cfg_ready cfg_*      | gain index 0..2, 24-bit Q8.16 gain
//
// an item is loaded, runs one pid step per step count (zero steps run as one), and then
// moves into the output register once that register is free
// a step finds the error, uses the shared 32x24 multiplier, then sums and updates
// rst is synchronous; it clears the gains, the sequencer and the output valid
// a finished word waits in the output register while the next word is accepted;
// the sequencer holds only if a second result is ready before the first is taken
module pid_velocity_iterate
  import pvi_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [IN_W-1:0]     s_tdata,   // target_setpoint, start_velocity, step_count
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [VEL_W-1:0]         m_tdata,   // final_velocity
  output logic                     m_tuser,   // saturated
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [GAIN_W-1:0]   cfg_data
);

  state_t state, state_next;
  logic [UPC_W-1:0] upc;
  logic [COUNT_BITS-1:0] cnt;
  ctrl_word_t cw;

  logic signed [GAIN_W-1:0] kp, ki, kd;
  logic signed [VEL_W-1:0]  tgt, vel, err, last_err, diff, sum;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic                     sat_flag;

  logic in_acc, out_free, last_step;
  logic signed [VEL_W-1:0]  mul_a;
  logic signed [GAIN_W-1:0] mul_b;
  logic signed [ACC_W-1:0]  prod_ext, prod10, acc_next;
  sat_t err_s, diff_s, sum_s, vel_s;
  logic [COUNT_BITS-1:0] cnt_in;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cw        = ucode(upc);
  assign last_step = (cnt == COUNT_BITS'(1));
  assign cnt_in    = s_tdata[64 +: COUNT_BITS];

  // gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kp <= '0;
      ki <= '0;
      kd <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PROP:  kp <= cfg_data;
        CFG_INTEG: ki <= cfg_data;
        CFG_DERIV: kd <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_acc) state_next = ST_RUN;
      ST_RUN:   if (cw.loop_end && last_step) state_next = ST_FLUSH;
      ST_FLUSH: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // microprogram counter and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UPC_FIRST;
      cnt <= '0;
    end else if (in_acc) begin
      upc <= UPC_FIRST;
      cnt <= (cnt_in == '0) ? COUNT_BITS'(1) : cnt_in;
    end else if (state == ST_RUN) begin
      if (cw.loop_end) begin
        upc <= UPC_FIRST;
        cnt <= cnt - COUNT_BITS'(1);
      end else begin
        upc <= upc + UPC_W'(1);
      end
    end
  end

  // shared multiplier operands
  always_comb begin
    case (cw.a_sel)
      A_ERR:   mul_a = err;
      A_DIFF:  mul_a = diff;
      A_SUM:   mul_a = sum;
      default: mul_a = err;
    endcase
    case (cw.b_sel)
      B_KP:    mul_b = kp;
      B_KI:    mul_b = ki;
      B_KD:    mul_b = kd;
      B_DT:    mul_b = DT_Q16;
      default: mul_b = kp;
    endcase
  end

  // error, difference, sum and velocity updates with clamping
  always_comb begin
    err_s    = sat32(WIDE_W'(tgt) - WIDE_W'(vel));
    diff_s   = sat32(WIDE_W'(err) - WIDE_W'(last_err));
    sum_s    = sat32(WIDE_W'(sum) + WIDE_W'(rnd_prod(prod)));
    vel_s    = sat32(WIDE_W'(vel) + WIDE_W'(rnd_acc(acc)));
    prod_ext = ACC_W'(prod);
    prod10   = (prod_ext <<< 3) + (prod_ext <<< 1);
    case (cw.acc_op)
      ACC_LOAD:  acc_next = prod_ext;
      ACC_ADD:   acc_next = acc + prod_ext;
      ACC_ADD10: acc_next = acc + prod10;
      default:   acc_next = acc;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tgt      <= s_tdata[31:0];
      vel      <= s_tdata[63:32];
      last_err <= '0;
      sum      <= '0;
      sat_flag <= 1'b0;
    end else if (state == ST_RUN) begin
      if (cw.ld_err) begin
        err <= err_s.val;
        if (err_s.ovf) sat_flag <= 1'b1;
      end
      if (cw.ld_diff) begin
        diff     <= diff_s.val;
        last_err <= err;
        if (diff_s.ovf) sat_flag <= 1'b1;
      end
      if (cw.ld_sum) begin
        sum <= sum_s.val;
        if (sum_s.ovf) sat_flag <= 1'b1;
      end
      if (cw.ld_vel) begin
        vel <= vel_s.val;
        if (vel_s.ovf) sat_flag <= 1'b1;
      end
      if (cw.mul_en) prod <= mul_a * mul_b;
      acc <= acc_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FLUSH && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FLUSH && out_free) begin
      m_tdata <= vel;
      m_tuser <= sat_flag;
    end
  end

  // checks
  a_start_run : assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == ST_RUN) && (upc == UPC_FIRST) && (cnt != '0))
    else $error("sequencer did not start a run");

  a_cnt_live : assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (cnt != '0))
    else $error("step counter ran out inside a run");

  a_upc_range : assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (upc <= UPC_W'(6)))
    else $error("microprogram counter left the program");

  a_out_src : assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_FLUSH))
    else $error("result word appeared outside flush");

  a_flush_hold : assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) && !out_free |=> (state == ST_FLUSH))
    else $error("result dropped while output busy");

endmodule

`default_nettype wire
